// File: hdl/ballot_tally_with_voter_dedup_defines.svh
// ----------------------------------------------------------------------------
// Ballot tally assertion macros
// Shared concurrent assertion forms for the ballot tally checker.
// ----------------------------------------------------------------------------
`ifndef BALLOT_TALLY_WITH_VOTER_DEDUP_DEFINES_SVH
`define BALLOT_TALLY_WITH_VOTER_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BTV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btv check failed (same cycle)");

// Next-cycle implication, disabled while reset is low.
`define BTV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btv check failed (next cycle)");

`endif

// File: hdl/btv_pkg.sv
// ----------------------------------------------------------------------------
// Ballot tally package
// Sizes, payload structs, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package btv_pkg;

    // Store sizes
    localparam int MAX_CANDS   = 32;
    localparam int MAX_BALLOTS = 1024;

    // Derived store widths
    localparam int CAND_AW = $clog2(MAX_CANDS);
    localparam int VID_AW  = $clog2(MAX_BALLOTS);
    localparam int CC_W    = $clog2(MAX_CANDS + 1);
    localparam int VC_W    = $clog2(MAX_BALLOTS + 1);
    localparam int SCAN_W  = (VC_W > CC_W) ? VC_W : CC_W;

    // Fixed field widths
    localparam int NUM_W       = 32;
    localparam int ID_W        = 37;
    localparam int LEN_W       = 6;
    localparam int SLOT_W      = 5;
    localparam int CNT_W       = 11;
    localparam int TOTAL_W     = 11;
    localparam int REG_TOTAL_W = 6;

    localparam logic [LEN_W-1:0] ID_DIGITS = LEN_W'(11);

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_VOTE     = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CAND_FULL = 3'd1,
        ST_NOT_POS   = 3'd2,
        ST_TAKEN     = 3'd3,
        ST_BOX_FULL  = 3'd4,
        ST_BAD_LEN   = 3'd5,
        ST_VOTED     = 3'd6,
        ST_NO_CAND   = 3'd7
    } t_status;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [NUM_W-1:0]  candidate_number;
        logic [ID_W-1:0]          voter_id;
        logic [LEN_W-1:0]         voter_id_length;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        candidate_slot;
        logic [CNT_W-1:0]         slot_vote_count;
        logic [TOTAL_W-1:0]       ballot_total;
        logic [REG_TOTAL_W-1:0]   registered_total;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic    latch;
        logic    scan_start;
        logic    scan_cand;
        logic    scan_run;
        logic    set_err;
        t_status err_code;
        logic    reg_ok;
        logic    vote_ok;
        logic    load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    cand_full;
        logic    not_pos;
        logic    box_full;
        logic    bad_len;
        logic    scan_done;
        logic    scan_hit;
        logic    out_free;
    } t_sts;

endpackage

// File: hdl/btv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module btv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/btv_ctrl.sv
// ----------------------------------------------------------------------------
// Ballot tally controller
// Sequences checks, table scans and store updates for one request.
// ----------------------------------------------------------------------------
module btv_ctrl import btv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_ID,
        S_SCAN_CAND,
        S_VOTE_RD,
        S_VOTE_WR,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.op == OP_REGISTER) begin
                    if (i_sts.cand_full) begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_CAND_FULL;
                        n_state        = S_FINISH;
                    end else if (i_sts.not_pos) begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_NOT_POS;
                        n_state        = S_FINISH;
                    end else begin
                        n_cmd.scan_start = 1'b1;
                        n_cmd.scan_cand  = 1'b1;
                        n_state          = S_SCAN_CAND;
                    end
                end else begin
                    if (i_sts.box_full) begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_BOX_FULL;
                        n_state        = S_FINISH;
                    end else if (i_sts.bad_len) begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_BAD_LEN;
                        n_state        = S_FINISH;
                    end else begin
                        n_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN_ID;
                    end
                end
            end
            S_SCAN_ID: begin
                n_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.scan_hit) begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_VOTED;
                        n_state        = S_FINISH;
                    end else begin
                        n_cmd.scan_start = 1'b1;
                        n_cmd.scan_cand  = 1'b1;
                        n_state          = S_SCAN_CAND;
                    end
                end
            end
            S_SCAN_CAND: begin
                n_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.op == OP_REGISTER) begin
                        if (i_sts.scan_hit) begin
                            n_cmd.set_err  = 1'b1;
                            n_cmd.err_code = ST_TAKEN;
                        end else begin
                            n_cmd.reg_ok = 1'b1;
                        end
                        n_state = S_FINISH;
                    end else if (i_sts.scan_hit) begin
                        n_state = S_VOTE_RD;
                    end else begin
                        n_cmd.set_err  = 1'b1;
                        n_cmd.err_code = ST_NO_CAND;
                        n_state        = S_FINISH;
                    end
                end
            end
            S_VOTE_RD: begin
                // vote count of the hit slot is read this cycle
                n_state = S_VOTE_WR;
            end
            S_VOTE_WR: begin
                n_cmd.vote_ok = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;
    assign o_cmd      = n_cmd;

endmodule

// File: hdl/btv_datapath.sv
// ----------------------------------------------------------------------------
// Ballot tally datapath
// Request latch, counters, store RAMs, scan unit and output register.
// ----------------------------------------------------------------------------
module btv_datapath import btv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_in                r_item;
    logic [CC_W-1:0]    r_cand_count;
    logic [VC_W-1:0]    r_vote_count;

    logic [SCAN_W-1:0]  r_scan_addr;
    logic [SCAN_W-1:0]  r_rd_idx;
    logic [SCAN_W-1:0]  r_hit_idx;
    logic               r_scan_cand;
    logic               r_rd_pend;
    logic               r_hit;

    t_status            r_res_status;
    logic [CAND_AW-1:0] r_res_slot;
    logic [VC_W-1:0]    r_res_cnt;

    logic               r_out_valid;
    t_out               r_out;

    logic [ID_W-1:0]    id_rdata;
    logic [NUM_W-1:0]   num_rdata;
    logic [VC_W-1:0]    votes_rdata;
    logic [VC_W-1:0]    n_slot_votes;

    logic [SCAN_W-1:0]  scan_limit;
    logic               scan_more;
    logic               rd_match;

    logic               votes_we;
    logic [CAND_AW-1:0] votes_waddr;
    logic [VC_W-1:0]    votes_wdata;

    // Stores
    btv_ram #(.WIDTH(ID_W), .DEPTH(MAX_BALLOTS)) u_voter_ids (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vote_ok),
        .i_waddr (r_vote_count[VID_AW-1:0]),
        .i_wdata (r_item.voter_id),
        .i_raddr (r_scan_addr[VID_AW-1:0]),
        .o_rdata (id_rdata)
    );

    btv_ram #(.WIDTH(NUM_W), .DEPTH(MAX_CANDS)) u_cand_numbers (
        .i_clk   (i_clk),
        .i_we    (i_cmd.reg_ok),
        .i_waddr (r_cand_count[CAND_AW-1:0]),
        .i_wdata (r_item.candidate_number),
        .i_raddr (r_scan_addr[CAND_AW-1:0]),
        .o_rdata (num_rdata)
    );

    assign votes_we     = i_cmd.reg_ok | i_cmd.vote_ok;
    assign votes_waddr  = i_cmd.reg_ok ? r_cand_count[CAND_AW-1:0] : r_hit_idx[CAND_AW-1:0];
    assign n_slot_votes = votes_rdata + VC_W'(1);
    assign votes_wdata  = i_cmd.reg_ok ? '0 : n_slot_votes;

    btv_ram #(.WIDTH(VC_W), .DEPTH(MAX_CANDS)) u_cand_votes (
        .i_clk   (i_clk),
        .i_we    (votes_we),
        .i_waddr (votes_waddr),
        .i_wdata (votes_wdata),
        .i_raddr (r_hit_idx[CAND_AW-1:0]),
        .o_rdata (votes_rdata)
    );

    // Scan: one address issued per cycle, compared in the cycle after
    assign scan_limit = r_scan_cand ? SCAN_W'(r_cand_count) : SCAN_W'(r_vote_count);
    assign scan_more  = !r_hit && (r_scan_addr < scan_limit);
    assign rd_match   = r_scan_cand ? (num_rdata == r_item.candidate_number)
                                    : (id_rdata == r_item.voter_id);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_start) begin
            r_scan_cand <= i_cmd.scan_cand;
        end
        if (!i_cmd.scan_start && i_cmd.scan_run) begin
            if (scan_more) begin
                r_rd_idx <= r_scan_addr;
            end
            if (r_rd_pend && rd_match && !r_hit) begin
                r_hit_idx <= r_rd_idx;
            end
        end
        if (i_cmd.set_err) begin
            r_res_status <= i_cmd.err_code;
            r_res_slot   <= '0;
            r_res_cnt    <= '0;
        end else if (i_cmd.reg_ok) begin
            r_res_status <= ST_OK;
            r_res_slot   <= r_cand_count[CAND_AW-1:0];
            r_res_cnt    <= '0;
        end else if (i_cmd.vote_ok) begin
            r_res_status <= ST_OK;
            r_res_slot   <= r_hit_idx[CAND_AW-1:0];
            r_res_cnt    <= n_slot_votes;
        end
        if (i_cmd.load_out) begin
            r_out.status           <= r_res_status;
            r_out.candidate_slot   <= SLOT_W'(r_res_slot);
            r_out.slot_vote_count  <= CNT_W'(r_res_cnt);
            r_out.ballot_total     <= TOTAL_W'(r_vote_count);
            r_out.registered_total <= REG_TOTAL_W'(r_cand_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_count <= '0;
            r_vote_count <= '0;
            r_scan_addr  <= '0;
            r_rd_pend    <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.reg_ok) begin
                r_cand_count <= r_cand_count + CC_W'(1);
            end
            if (i_cmd.vote_ok) begin
                r_vote_count <= r_vote_count + VC_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_rd_pend   <= 1'b0;
                r_hit       <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_rd_pend <= scan_more;
                if (scan_more) begin
                    r_scan_addr <= r_scan_addr + SCAN_W'(1);
                end
                if (r_rd_pend && rd_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to controller
    always_comb begin
        o_sts.op        = r_item.opcode;
        o_sts.cand_full = (r_cand_count >= CC_W'(MAX_CANDS));
        o_sts.not_pos   = (r_item.candidate_number == '0) || r_item.candidate_number[NUM_W-1];
        o_sts.box_full  = (r_vote_count >= VC_W'(MAX_BALLOTS));
        o_sts.bad_len   = (r_item.voter_id_length != ID_DIGITS);
        o_sts.scan_done = r_hit || (!scan_more && !r_rd_pend);
        o_sts.scan_hit  = r_hit;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/ballot_tally_with_voter_dedup.sv
// ----------------------------------------------------------------------------
// Ballot tally with voter deduplication
// Every request beat gives one result beat. A register request fills the
// next free slot of the candidate table after checking that the table has
// room, that the number is positive and that no registered candidate has it.
// A vote request checks that the ballot box has room and that the id is 11
// digits long, then scans every stored voter id, then scans the candidate
// table, and only then stores the id and counts the vote. The block takes
// one request at a time: the next request beat is stalled until the result
// of the last one has gone into the output register. The scans run through
// the voter id and candidate number RAMs one entry per cycle. A result
// waits in the output register while the next request beat is already
// taken. Stores come out of reset with unknown contents and need no
// clearing pass: only entries below the counts are ever read.
// ----------------------------------------------------------------------------
module ballot_tally_with_voter_dedup import btv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Controller: request sequencing, one state per phase
    btv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: stores, counters, scan unit, result register
    btv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hdl/btv_checker.sv
// ----------------------------------------------------------------------------
// Ballot tally checker
// Port-level checks on the ballot tally, bound to the top level.
// ----------------------------------------------------------------------------
`include "ballot_tally_with_voter_dedup_defines.svh"

module btv_checker import btv_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic                   r_seen;
    logic [TOTAL_W-1:0]     r_last_ballot;
    logic [REG_TOTAL_W-1:0] r_last_reg;
    logic                   out_beat;
    logic                   err_beat;
    logic                   err_clean;
    logic                   totals_up;

    assign out_beat  = o_out_valid && !i_out_stall;
    assign err_beat  = o_out_valid && (o_out_data.status != ST_OK);
    assign err_clean = (o_out_data.candidate_slot == '0)
                    && (o_out_data.slot_vote_count == '0);
    assign totals_up = (o_out_data.ballot_total >= r_last_ballot)
                    && (o_out_data.registered_total >= r_last_reg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_last_ballot <= '0;
            r_last_reg    <= '0;
        end else if (out_beat) begin
            r_seen        <= 1'b1;
            r_last_ballot <= o_out_data.ballot_total;
            r_last_reg    <= o_out_data.registered_total;
        end
    end

    // one request in flight: a taken beat closes the input
    `BTV_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a stalled result stays offered
    `BTV_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // refused requests report no slot and no count
    `BTV_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, err_beat, err_clean)

    // totals never go down between result beats
    `BTV_ASSERT_SAME(a_totals_grow, i_clk, i_rst_n, out_beat && r_seen, totals_up)

endmodule

bind ballot_tally_with_voter_dedup btv_checker u_checker (.*);

// File: dv/ballot_tally_with_voter_dedup_test.sv
// ----------------------------------------------------------------------------
// Ballot tally with voter deduplication: self-checking test
// Sends register and vote requests over the valid/stall request channel.
// Each accepted beat is run through a local model of the candidate table,
// the stored voter ids and the running totals. Every result beat is checked
// field by field against the oldest predicted result. The run covers the
// candidate table filling up and random idling on both sides.
// ----------------------------------------------------------------------------
module ballot_tally_with_voter_dedup_test;
    import btv_pkg::*;

    // The run has roughly 540 beats, and a vote scans the stored voter ids
    // and the candidate table; the limit allows for the slowest correct run
    // several times over.
    localparam int unsigned RUN_LIMIT        = 8_000_000;
    localparam int unsigned SETTLE_CYCLES    = 1200;
    localparam int unsigned RANDOM_PER_PHASE = 120;
    localparam int unsigned MAX_REPORTS      = 200;
    localparam bit [ID_W-1:0] ID_TOP_DIGITS  = 37'd99999999999;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data  = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // Beats waiting to be sent, and results still owed by the block
    t_in  ballot_pending[$];
    t_out tally_expect[$];

    // Local copy of the block's state, updated as beats are accepted
    bit [NUM_W-1:0] tally_numbers[MAX_CANDS];
    bit [CNT_W-1:0] tally_votes[MAX_CANDS];
    int unsigned    tally_cands = 0;
    bit [ID_W-1:0]  tally_ids[$];

    // What the stimulus has offered so far, used to steer it towards
    // registered numbers and repeated ids
    bit [NUM_W-1:0] offered_numbers[$];
    bit [ID_W-1:0]  offered_ids[$];
    bit             id_offered[bit [ID_W-1:0]];

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    ballot_tally_with_voter_dedup i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Tally model
    // ------------------------------------------------------------------

    // Slot of a registered candidate with this number, or -1.
    function automatic int cand_slot_of(bit [NUM_W-1:0] num);
        for (int i = 0; i < tally_cands; i++) begin
            if (tally_numbers[i] == num) return i;
        end
        return -1;
    endfunction

    // Applies one request to the model state and returns the result beat.
    // Rejected requests leave the state alone.
    function automatic t_out tally_apply(t_in req);
        t_out res;
        int   slot;
        bit   seen;
        res  = '0;
        slot = -1;
        seen = 1'b0;
        if (req.opcode == OP_REGISTER) begin
            // table full beats not positive beats taken
            if (tally_cands >= MAX_CANDS) begin
                res.status = ST_CAND_FULL;
            end else if ($signed(req.candidate_number) <= 32'sd0) begin
                res.status = ST_NOT_POS;
            end else if (cand_slot_of(req.candidate_number) >= 0) begin
                res.status = ST_TAKEN;
            end else begin
                slot = tally_cands;
                tally_numbers[slot] = req.candidate_number;
                tally_votes[slot]   = '0;
                tally_cands++;
                res.status = ST_OK;
            end
        end else begin
            // full 37-bit compare, ids above eleven digits included
            foreach (tally_ids[i]) begin
                if (tally_ids[i] == req.voter_id) seen = 1'b1;
            end
            // box full, then length, then already voted, then unknown number
            if (tally_ids.size() >= MAX_BALLOTS) begin
                res.status = ST_BOX_FULL;
            end else if (req.voter_id_length != ID_DIGITS) begin
                res.status = ST_BAD_LEN;
            end else if (seen) begin
                res.status = ST_VOTED;
            end else begin
                slot = cand_slot_of(req.candidate_number);
                if (slot < 0) begin
                    res.status = ST_NO_CAND;
                end else begin
                    tally_ids.push_back(req.voter_id);
                    tally_votes[slot]++;
                    res.status = ST_OK;
                end
            end
        end
        if (res.status == ST_OK) begin
            res.candidate_slot  = SLOT_W'(slot);
            res.slot_vote_count = tally_votes[slot];
        end
        res.ballot_total     = TOTAL_W'(tally_ids.size());
        res.registered_total = REG_TOTAL_W'(tally_cands);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit number_offered(bit [NUM_W-1:0] num);
        foreach (offered_numbers[i]) begin
            if (offered_numbers[i] == num) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Positive number not yet offered: half small, half across the range
    function automatic bit [NUM_W-1:0] fresh_number();
        bit [NUM_W-1:0] num;
        do begin
            if ($urandom_range(1)) num = $urandom_range(200, 1);
            else num = $urandom_range(32'h7FFF_FFFF, 1);
        end while (number_offered(num));
        return num;
    endfunction

    // Id not yet offered: half inside eleven digits, half over all 37 bits
    function automatic bit [ID_W-1:0] fresh_id();
        bit [ID_W-1:0] id;
        do begin
            if ($urandom_range(1)) id = ID_W'({$urandom, $urandom});
            else id = ID_W'({$urandom, $urandom} % 64'd100000000000);
        end while (id_offered.exists(id));
        return id;
    endfunction

    // Id and length are ignored on a register beat, so they carry junk
    task automatic queue_register(bit [NUM_W-1:0] num);
        t_in req;
        req                  = '0;
        req.opcode           = OP_REGISTER;
        req.candidate_number = num;
        req.voter_id         = ID_W'({$urandom, $urandom});
        req.voter_id_length  = LEN_W'($urandom);
        if ($signed(num) > 0 && !number_offered(num)) offered_numbers.push_back(num);
        ballot_pending.push_back(req);
    endtask

    task automatic queue_vote(bit [NUM_W-1:0] num, bit [ID_W-1:0] id,
                              bit [LEN_W-1:0] len);
        t_in req;
        req                  = '0;
        req.opcode           = OP_VOTE;
        req.candidate_number = num;
        req.voter_id         = id;
        req.voter_id_length  = len;
        if (!id_offered.exists(id)) begin
            id_offered[id] = 1'b1;
            offered_ids.push_back(id);
        end
        ballot_pending.push_back(req);
    endtask

    // Mostly well-formed votes for offered numbers with fresh ids; the rest
    // registers, repeats ids, mangles lengths or aims at unregistered numbers.
    task automatic queue_random_request();
        int unsigned    pick;
        bit [NUM_W-1:0] num;
        bit [ID_W-1:0]  id;
        bit [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 12) begin
            pick = $urandom_range(99);
            if (pick < 60) num = fresh_number();
            else if (pick < 80) num = offered_numbers[$urandom_range(offered_numbers.size() - 1)];
            else if (pick < 88) num = '0;
            else num = {1'b1, 31'($urandom)};
            queue_register(num);
        end else begin
            pick = $urandom_range(99);
            if (pick < 80) num = offered_numbers[$urandom_range(offered_numbers.size() - 1)];
            else if (pick < 90) num = $urandom;
            else num = fresh_number();
            len = ($urandom_range(99) < 88) ? ID_DIGITS : LEN_W'($urandom);
            if ($urandom_range(99) < 80) id = fresh_id();
            else id = offered_ids[$urandom_range(offered_ids.size() - 1)];
            queue_vote(num, id, len);
        end
    endtask

    // Sampled on the falling edge so that the posedge updates have settled
    task automatic wait_drained();
        while (ballot_pending.size() != 0 || in_valid || tally_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int unsigned gap_pct, int unsigned stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE) queue_random_request();
        wait_drained();
    endtask

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Request driver: one beat in flight, held steady while stalled. The
    // decision to idle is only taken with no beat on the channel.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) tally_expect.push_back(tally_apply(in_data));
            if (!in_valid || !in_stall) begin
                if (ballot_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= ballot_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall, and a field-by-field check of every
    // accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_out want;
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (tally_expect.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result beat with none expected, status %0d",
                             $time, out_data.status);
            end else begin
                want = tally_expect.pop_front();
                if (out_data.status !== want.status)
                    report_field("status", 32'(want.status), 32'(out_data.status));
                if (out_data.candidate_slot !== want.candidate_slot)
                    report_field("candidate_slot", 32'(want.candidate_slot),
                                 32'(out_data.candidate_slot));
                if (out_data.slot_vote_count !== want.slot_vote_count)
                    report_field("slot_vote_count", 32'(want.slot_vote_count),
                                 32'(out_data.slot_vote_count));
                if (out_data.ballot_total !== want.ballot_total)
                    report_field("ballot_total", 32'(want.ballot_total),
                                 32'(out_data.ballot_total));
                if (out_data.registered_total !== want.registered_total)
                    report_field("registered_total", 32'(want.registered_total),
                                 32'(out_data.registered_total));
            end
        end
    end

    // Hung or lost results end up here
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("ballot_tally_with_voter_dedup: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes and every check of both operations
        queue_register(32'd1);                          // lowest positive
        queue_register(32'h7FFF_FFFF);                  // highest positive
        queue_register(32'd0);                          // zero is not positive
        queue_register(32'hFFFF_FFFF);                  // minus one
        queue_register(32'h8000_0000);                  // most negative
        queue_register(32'd1);                          // number taken
        queue_vote(32'd1, '0, ID_DIGITS);               // id zero
        queue_vote(32'd1, '0, ID_DIGITS);               // same id again
        queue_vote(32'h7FFF_FFFF, '1, ID_DIGITS);       // id above eleven digits
        queue_vote(32'h7FFF_FFFF, ID_TOP_DIGITS, ID_DIGITS);
        queue_vote(32'd1, 37'd5, 6'd0);                 // length checks
        queue_vote(32'd1, 37'd5, 6'd63);
        queue_vote(32'd1, 37'd5, 6'd10);
        queue_vote(32'd1, 37'd5, 6'd12);
        queue_vote(32'd1, '0, 6'd12);                   // length before repeat id
        queue_vote(32'd5, '0, ID_DIGITS);               // repeat id before unknown number
        queue_vote(32'd5, 37'd6, ID_DIGITS);            // unknown number
        queue_vote(32'd0, 37'd7, ID_DIGITS);            // non-positive: never registered
        queue_vote(32'h8000_0000, 37'd8, ID_DIGITS);
        queue_vote(32'hFFFF_FFFF, 37'd9, ID_DIGITS);
        queue_vote(32'd1, 37'd9, ID_DIGITS);            // refused id was not stored
        queue_vote(32'd1, 37'h10_0000_0000, ID_DIGITS); // differs from zero in top bit only
        wait_drained();

        // Random phases; each ends with the sender held off until drained
        run_random_phase(0, 0);
        run_random_phase(45, 0);
        run_random_phase(0, 45);
        run_random_phase(22, 22);

        // Fill the candidate table, then knock on it while full
        send_gap_pct   = 22;
        recv_stall_pct = 22;
        while (tally_cands + ballot_pending.size() < MAX_CANDS) queue_register(fresh_number());
        queue_register(fresh_number());
        queue_register(offered_numbers[0]);             // taken, but full wins
        queue_register(32'd0);                          // not positive, but full wins
        wait_drained();

        // Give the block time to show any stray result beat
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("ballot_tally_with_voter_dedup: match");
        end else begin
            $display("ballot_tally_with_voter_dedup: mismatch");
        end
        $finish;
    end

endmodule
